// File: hw/rtl/scs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg
// shared types and codes for the sparse column store
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int CMD_W   = 3;
    localparam int IPOS_W  = 16;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;
    localparam int EPS_W   = 31;

    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIV    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRUNE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    localparam logic [VAL_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

    localparam logic [EPS_W-1:0] EPS_RESET = 31'd1;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IPOS_W-1:0]        position;
        logic signed [VAL_W-1:0]  operand;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic [CNT_W-1:0]         entry_count;
        logic [STAT_W-1:0]        status;
    } t_out_word;

    // divider handshake
    typedef struct packed {
        logic                     start;
        logic signed [VAL_W-1:0]  dividend;
        logic signed [VAL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [VAL_W-1:0]  quotient;
        logic                     sat;
    } t_div_rsp;

endpackage : scs_pkg
`default_nettype wire

// File: hw/rtl/scs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scs_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule : scs_ram
`default_nettype wire

// File: hw/rtl/scs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scs_div
// iterative q16.16 divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module scs_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire scs_pkg::t_div_req i_req,
    output scs_pkg::t_div_rsp     o_rsp
);

    // dividend magnitude is at most 2^47, quotient needs 48 bits
    localparam int NUM_W = 48;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num, n_num;
    logic [32:0]       r_rem, n_rem;
    logic [31:0]       r_den;
    logic              r_neg;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_done;

    logic [33:0]       trial;
    logic [32:0]       shifted;

    always_comb begin
        shifted = {r_rem[31:0], r_num[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        n_num   = {r_num[NUM_W-2:0], ~trial[33]};
        n_rem   = trial[33] ? shifted : trial[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {(i_req.dividend[31] ? 32'(-i_req.dividend) : 32'(i_req.dividend)),
                      16'h0000};
            r_den <= i_req.divisor[31] ? 32'(-i_req.divisor) : 32'(i_req.divisor);
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.sat  = 1'b0;
        if (r_neg) begin
            if (r_num > 48'h0000_8000_0000) begin
                o_rsp.sat      = 1'b1;
                o_rsp.quotient = scs_pkg::Q_MIN;
            end else begin
                o_rsp.quotient = 32'(-r_num[31:0]);
            end
        end else begin
            if (r_num > 48'h0000_7fff_ffff) begin
                o_rsp.sat      = 1'b1;
                o_rsp.quotient = scs_pkg::Q_MAX;
            end else begin
                o_rsp.quotient = r_num[31:0];
            end
        end
    end

endmodule : scs_div
`default_nettype wire

// File: hw/rtl/sparse_column_store_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_column_store_core
// bounded table of (position, q16.16 value) entries for one sparse column
// ----------------------------------------------------------------------------
// usage: the input channel takes one command word (cmd, position, operand);
// every word yields exactly one result word (value, entry_count, status) on
// the output channel. the eps threshold for prune sits in an apb register
// at address 0 and should be written only while the block is idle.
// sequence: each command first scans the table, one slot per cycle through
// the position and value rams; a divide by a nonzero operand then waits on
// the iterative divider, and a command that writes the rams passes a write
// state before the result word is offered. prune is a single scan that
// rewrites used bits as it walks. one command is in flight at a time.
// reset clears the used bits (flip-flops) and the count and sets the
// threshold to 1; the rams need no clearing since data from an unused slot is never used.
// when the receiver stalls, the result is held in the output register and
// the next command is taken no earlier than the cycle after that result left.
// ----------------------------------------------------------------------------
module sparse_column_store_core #(
    parameter int CAPACITY  = 64,
    parameter int POS_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire scs_pkg::t_in_word     i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output scs_pkg::t_out_word         o_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [1:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ACT   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [scs_pkg::EPS_W-1:0] r_eps;
    logic [CAPACITY-1:0]       r_used;
    logic [CW-1:0]             r_count;
    logic [scs_pkg::CMD_W-1:0] r_cmd;
    logic [POS_WIDTH-1:0]      r_pos;
    logic [31:0]               r_opnd;
    logic [AW:0]               r_idx;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_rd_slot;
    logic                      r_hit;
    logic [AW-1:0]             r_hit_slot;
    logic [31:0]               r_hit_val;
    logic [31:0]               r_new_val;
    logic [31:0]               r_res;
    logic [scs_pkg::STAT_W-1:0] r_stat;
    logic                      r_wr_pos;

    logic [POS_WIDTH-1:0]      pos_rdata;
    logic [31:0]               val_rdata;
    logic                      ram_we;
    logic [AW-1:0]             ram_addr;
    logic                      in_acc;

    scs_pkg::t_div_req div_req;
    scs_pkg::t_div_rsp div_rsp;

    // lowest free slot by priority scan over the used bits
    logic [AW-1:0] free_slot;
    logic          free_any;
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = AW'(k);
                free_any  = 1'b1;
            end
        end
    end

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = {1'b0, r_eps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= scs_pkg::EPS_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_eps <= pwdata[scs_pkg::EPS_W-1:0];
        end
    end

    assign ram_we   = (r_state == S_WRITE);
    assign ram_addr = (r_state == S_WRITE) ? r_hit_slot : r_idx[AW-1:0];

    scs_ram #(.WIDTH(POS_WIDTH), .DEPTH(CAPACITY)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && r_wr_pos),
        .i_addr  (ram_addr),
        .i_wdata (r_pos),
        .o_rdata (pos_rdata)
    );

    scs_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_new_val),
        .o_rdata (val_rdata)
    );

    assign div_req.start    = (r_state == S_ACT) && r_hit && (r_cmd == scs_pkg::CMD_DIV)
                              && (r_opnd != '0);
    assign div_req.dividend = r_hit_val;
    assign div_req.divisor  = r_opnd;

    scs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    logic [32:0] sum;
    logic [31:0] mag;
    assign sum = {r_hit_val[31], r_hit_val} + {r_opnd[31], r_opnd};
    assign mag = val_rdata[31] ? 32'(-val_rdata) : val_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd    <= i_data.cmd;
                        r_pos    <= POS_WIDTH'(i_data.position);
                        r_opnd   <= i_data.operand;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_rd_vld <= 1'b0;
                        r_res    <= '0;
                        r_stat   <= scs_pkg::ST_OK;
                        r_wr_pos <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read address r_idx, data of previous slot arrives now
                    r_rd_vld  <= (r_idx < (AW+1)'(CAPACITY));
                    r_rd_slot <= r_idx[AW-1:0];
                    if (r_idx < (AW+1)'(CAPACITY)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_vld && r_used[r_rd_slot]) begin
                        if (r_cmd == scs_pkg::CMD_PRUNE) begin
                            if (mag <= {1'b0, r_eps}) begin
                                r_used[r_rd_slot] <= 1'b0;
                                r_count <= r_count - 1'b1;
                            end
                        end else if (pos_rdata == r_pos) begin
                            r_hit      <= 1'b1;
                            r_hit_slot <= r_rd_slot;
                            r_hit_val  <= val_rdata;
                        end
                    end
                    if (!r_rd_vld && r_idx == (AW+1)'(CAPACITY)) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    r_state <= S_OUT;
                    case (r_cmd)
                        scs_pkg::CMD_SET, scs_pkg::CMD_ADD: begin
                            if (r_hit) begin
                                if (r_cmd == scs_pkg::CMD_SET) begin
                                    r_new_val <= r_opnd;
                                    r_res     <= r_opnd;
                                end else if (sum[32] != sum[31]) begin
                                    r_new_val <= sum[32] ? scs_pkg::Q_MIN : scs_pkg::Q_MAX;
                                    r_res     <= sum[32] ? scs_pkg::Q_MIN : scs_pkg::Q_MAX;
                                    r_stat    <= scs_pkg::ST_SAT;
                                end else begin
                                    r_new_val <= sum[31:0];
                                    r_res     <= sum[31:0];
                                end
                                r_state <= S_WRITE;
                            end else if (free_any) begin
                                r_hit_slot <= free_slot;
                                r_used[free_slot] <= 1'b1;
                                r_count   <= r_count + 1'b1;
                                r_new_val <= r_opnd;
                                r_res     <= r_opnd;
                                r_wr_pos  <= 1'b1;
                                r_state   <= S_WRITE;
                            end else begin
                                r_stat <= scs_pkg::ST_FULL;
                            end
                        end
                        scs_pkg::CMD_DIV: begin
                            if (r_hit) begin
                                if (r_opnd == '0) begin
                                    r_stat <= scs_pkg::ST_SAT;
                                    if (r_hit_val[31]) begin
                                        r_new_val <= scs_pkg::Q_MIN;
                                        r_res     <= scs_pkg::Q_MIN;
                                    end else if (r_hit_val != '0) begin
                                        r_new_val <= scs_pkg::Q_MAX;
                                        r_res     <= scs_pkg::Q_MAX;
                                    end else begin
                                        r_new_val <= '0;
                                        r_res     <= '0;
                                    end
                                    r_state <= S_WRITE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                        end
                        scs_pkg::CMD_TAKE: begin
                            if (r_hit) begin
                                r_res     <= r_hit_val;
                                r_new_val <= '0;
                                r_state   <= S_WRITE;
                            end
                        end
                        scs_pkg::CMD_READ: begin
                            if (r_hit) begin
                                r_res <= r_hit_val;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_new_val <= div_rsp.quotient;
                        r_res     <= div_rsp.quotient;
                        if (div_rsp.sat) begin
                            r_stat <= scs_pkg::ST_SAT;
                        end
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid            <= 1'b1;
                        o_data.value       <= r_res;
                        o_data.entry_count <= scs_pkg::CNT_W'(r_count);
                        o_data.status      <= r_stat;
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // count always matches the number of used slots, checked while idle
    a_count_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'($countones(r_used)) == r_count))
        else $error("entry count out of step with used slots");

    // a word is offered only once the command has finished
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result offered outside output state");

    // the divider only finishes while a divide is pending
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished with no divide pending");
`endif

endmodule : sparse_column_store_core
`default_nettype wire
